// ----- rtl/mrfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver package
// Shared types, function codes and the byte-wide CRC-16/Modbus update.
// ----------------------------------------------------------------------------
package mrfr_pkg;

  localparam int unsigned MaxFrameBytesDefault = 256;
  localparam int unsigned TimeoutW             = 16;
  localparam int unsigned TimeW                = 32;
  localparam int unsigned ByteW                = 8;
  localparam int unsigned PosW                 = 8;
  localparam int unsigned LenW                 = 9;
  localparam int unsigned ExpW                 = 10;
  localparam int unsigned CrcW                 = 16;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd5;
  localparam logic [CrcW-1:0]     CrcInit      = 16'hFFFF;
  localparam logic [CrcW-1:0]     CrcPoly      = 16'hA001;

  localparam logic [ExpW-1:0] FixedFrameLen  = 10'd8;
  localparam logic [ExpW-1:0] WriteMultiBase = 10'd9;
  localparam logic [ExpW-1:0] LenKnownAfter  = 10'd4;
  localparam logic [ExpW-1:0] ByteCountAfter = 10'd7;
  localparam int unsigned     FuncCodeOffset  = 1;
  localparam int unsigned     ByteCountOffset = 6;

  localparam logic [ByteW-1:0] FcReadHolding   = 8'd3;
  localparam logic [ByteW-1:0] FcReadInput     = 8'd4;
  localparam logic [ByteW-1:0] FcWriteCoil     = 8'd5;
  localparam logic [ByteW-1:0] FcWriteRegister = 8'd6;
  localparam logic [ByteW-1:0] FcWriteMultiple = 8'd16;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic [TimeW-1:0] now_ms;
  } mrfr_item_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_echo;
    logic [PosW-1:0]  byte_position;
    logic             byte_stored;
    logic             gap_restart;
    logic             frame_end;
    logic             crc_good;
    logic [LenW-1:0]  frame_length;
  } mrfr_result_t;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] data);
    logic [CrcW-1:0] crc;
    crc = crc_in ^ {8'd0, data};
    for (int k = 0; k < ByteW; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/mrfr_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register
// Captures one received byte and its timestamp and holds it until the
// frame logic moves it on to the result register.
// ----------------------------------------------------------------------------
module mrfr_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mrfr_pkg::mrfr_item_t item_i,
  input  logic                out_free_i,
  output logic                step_o,
  output mrfr_pkg::mrfr_item_t item_o
);
  import mrfr_pkg::*;

  logic       valid_q;
  logic       valid_d;
  mrfr_item_t item_q;

  assign step_o     = valid_q && out_free_i;
  assign in_ready_o = !valid_q || step_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/mrfr_frame_ctrl.sv -----
// ----------------------------------------------------------------------------
// Frame control
// Holds the frame state and the gap timeout, checks the inter-byte gap,
// counts bytes, runs the CRC and decides where the frame ends.
// ----------------------------------------------------------------------------
module mrfr_frame_ctrl #(
  parameter int unsigned MAX_FRAME_BYTES = mrfr_pkg::MaxFrameBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrfr_pkg::TimeoutW-1:0] cfg_timeout_i,
  input  logic                          step_i,
  input  mrfr_pkg::mrfr_item_t          item_i,
  output mrfr_pkg::mrfr_result_t        result_o
);
  import mrfr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);

  logic [TimeoutW-1:0] timeout_q;
  logic                receiving_q;
  logic [CntW-1:0]     count_q;
  logic [CrcW-1:0]     crc_q;
  logic [TimeW-1:0]    last_time_q;
  logic [ByteW-1:0]    func_q;
  logic [ByteW-1:0]    data_cnt_q;

  logic                receiving_d;
  logic [CntW-1:0]     count_d;
  logic [CrcW-1:0]     crc_d;
  logic [ByteW-1:0]    func_d;
  logic [ByteW-1:0]    data_cnt_d;

  logic [TimeW-1:0]    gap;
  logic                restart;
  logic [CntW-1:0]     cnt_base;
  logic [CrcW-1:0]     crc_base;
  logic                stored;
  logic [CrcW-1:0]     crc_new;
  logic [ExpW-1:0]     cnt_inc;
  logic [ExpW-1:0]     expected;
  logic                fend;
  logic [LenW-1:0]     cnt_wide;

  always_comb begin
    gap      = item_i.now_ms - last_time_q;
    restart  = receiving_q && (gap > {{(TimeW-TimeoutW){1'b0}}, timeout_q});
    cnt_base = restart ? '0 : count_q;
    crc_base = restart ? CrcInit : crc_q;
    stored   = cnt_base < CntW'(MAX_FRAME_BYTES);
    cnt_wide = LenW'(cnt_base);

    func_d     = (cnt_base == CntW'(FuncCodeOffset)) ? item_i.rx_byte : func_q;
    data_cnt_d = (cnt_base == CntW'(ByteCountOffset)) ? item_i.rx_byte : data_cnt_q;
    crc_new    = crc_byte(crc_base, item_i.rx_byte);
    cnt_inc    = ExpW'(cnt_base) + ExpW'(1);

    unique case (func_d)
      FcReadHolding, FcReadInput, FcWriteCoil, FcWriteRegister: begin
        expected = FixedFrameLen;
      end
      FcWriteMultiple: begin
        expected = (cnt_inc >= ByteCountAfter) ?
                   (WriteMultiBase + ExpW'(data_cnt_d)) : '0;
      end
      default: begin
        expected = '0;
      end
    endcase

    fend = stored && (cnt_inc >= LenKnownAfter) && (expected != '0) &&
           (cnt_inc >= expected);

    receiving_d = !fend;
    if (!stored) begin
      count_d = cnt_base;
      crc_d   = crc_base;
    end else if (fend) begin
      count_d = '0;
      crc_d   = CrcInit;
    end else begin
      count_d = cnt_inc[CntW-1:0];
      crc_d   = crc_new;
    end

    result_o.byte_echo     = item_i.rx_byte;
    result_o.byte_position = stored ? cnt_wide[PosW-1:0] : {PosW{1'b1}};
    result_o.byte_stored   = stored;
    result_o.gap_restart   = restart;
    result_o.frame_end     = fend;
    result_o.crc_good      = fend && (crc_new == '0);
    result_o.frame_length  = fend ? cnt_inc[LenW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_timeout_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      count_q     <= '0;
      crc_q       <= CrcInit;
      last_time_q <= '0;
      func_q      <= '0;
      data_cnt_q  <= '0;
    end else if (step_i) begin
      receiving_q <= receiving_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
      last_time_q <= item_i.now_ms;
      if (stored) begin
        func_q     <= func_d;
        data_cnt_q <= data_cnt_d;
      end
    end
  end

endmodule

// ----- rtl/mrfr_out_stage.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mrfr_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  mrfr_pkg::mrfr_result_t result_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mrfr_pkg::mrfr_result_t result_o
);
  import mrfr_pkg::*;

  logic         valid_q;
  logic         valid_d;
  mrfr_result_t result_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ----- rtl/modbus_rtu_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver core
// Byte-by-byte frame delimiting with gap timeout and CRC-16/Modbus check.
// ----------------------------------------------------------------------------
// The core accepts one received byte per clock cycle while results are taken
// and returns one result per byte: an input register feeds the frame logic,
// which updates the frame state and loads the result register in the same
// cycle. Throughput is limited only by the output side taking results.
// The gap timeout register may be written only while no byte is in flight.
module modbus_rtu_frame_receiver_core #(
  parameter int unsigned MAX_FRAME_BYTES = mrfr_pkg::MaxFrameBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_gap_timeout_we_i,
  input  logic [mrfr_pkg::TimeoutW-1:0] byte_gap_timeout_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mrfr_pkg::ByteW-1:0]    rx_byte_i,
  input  logic [mrfr_pkg::TimeW-1:0]    now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mrfr_pkg::ByteW-1:0]    byte_echo_o,
  output logic [mrfr_pkg::PosW-1:0]     byte_position_o,
  output logic                          byte_stored_o,
  output logic                          gap_restart_o,
  output logic                          frame_end_o,
  output logic                          crc_good_o,
  output logic [mrfr_pkg::LenW-1:0]     frame_length_o
);
  import mrfr_pkg::*;

  mrfr_item_t   in_item;
  mrfr_item_t   held_item;
  mrfr_result_t next_result;
  mrfr_result_t out_result;
  logic         step;
  logic         out_free;

  assign in_item.rx_byte = rx_byte_i;
  assign in_item.now_ms  = now_ms_i;

  mrfr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .out_free_i (out_free),
    .step_o     (step),
    .item_o     (held_item)
  );

  mrfr_frame_ctrl #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (byte_gap_timeout_we_i),
    .cfg_timeout_i (byte_gap_timeout_i),
    .step_i        (step),
    .item_i        (held_item),
    .result_o      (next_result)
  );

  mrfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (next_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign byte_echo_o     = out_result.byte_echo;
  assign byte_position_o = out_result.byte_position;
  assign byte_stored_o   = out_result.byte_stored;
  assign gap_restart_o   = out_result.gap_restart;
  assign frame_end_o     = out_result.frame_end;
  assign crc_good_o      = out_result.crc_good;
  assign frame_length_o  = out_result.frame_length;

endmodule
